// ===== hw/rtl/tfc_pkg.sv =====
package tfc_pkg;

    localparam int PlaneW = 64;
    localparam int KeyW   = 2 * PlaneW;
    localparam int Rows   = 8;
    localparam int Cols   = 8;

    typedef logic [PlaneW-1:0] plane_t;
    typedef logic [KeyW-1:0]   key_t;

    typedef struct packed {
        plane_t high;
        plane_t low;
    } tile_t;

    typedef struct packed {
        tile_t tile;
        logic  mirror_v;
        logic  mirror_h;
    } result_t;

    // reverse bit order inside every byte (left-right mirror)
    function automatic plane_t mirror_rows(input plane_t p);
        plane_t r;
        r = '0;
        for (int y = 0; y < Rows; y++)
        begin
            for (int b = 0; b < Cols; b++)
            begin
                r[Cols*y + (Cols-1-b)] = p[Cols*y + b];
            end
        end
        return r;
    endfunction

    // reverse byte order (top-bottom mirror)
    function automatic plane_t mirror_cols(input plane_t p);
        plane_t r;
        r = '0;
        for (int y = 0; y < Rows; y++)
        begin
            r[Cols*(Rows-1-y) +: Cols] = p[Cols*y +: Cols];
        end
        return r;
    endfunction

    function automatic tile_t flip_tile(input tile_t t, input logic fh, input logic fv);
        tile_t r;
        r = t;
        if (fh)
        begin
            r.low  = mirror_rows(r.low);
            r.high = mirror_rows(r.high);
        end
        if (fv)
        begin
            r.low  = mirror_cols(r.low);
            r.high = mirror_cols(r.high);
        end
        return r;
    endfunction

    // ordering key: pixel (0,0) in the top two bits, row-major
    function automatic key_t make_key(input tile_t t);
        key_t k;
        k = '0;
        for (int y = 0; y < Rows; y++)
        begin
            for (int x = 0; x < Cols; x++)
            begin
                k[KeyW-1 - 2*(Cols*y + x)] = t.high[Cols*y + (Cols-1-x)];
                k[KeyW-2 - 2*(Cols*y + x)] = t.low[Cols*y + (Cols-1-x)];
            end
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/tile_flip_canonicalizer_top.sv =====
// Tile flip canonicalizer: each item on s_* is one 8x8 tile of 2-bit pixels as two
// bitplanes; each item on m_* is the least of its four mirror images (none,
// left-right, top-bottom, both), compared pixel by pixel in row-major order, ties
// kept in that order, with the two flip flags in m_tuser. One item per cycle while
// the output is not stalled. Stages: an input register, then the mirror/compare
// logic into the output register. Back pressure holds each full stage in place;
// an empty input stage still takes an item while the output waits.
module tile_flip_canonicalizer_top
    import tfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // tile_low_plane, tile_high_plane
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // canon_low_plane, canon_high_plane
    output logic [1:0]   m_tuser    // mirrored_horizontally, mirrored_vertically
);

    logic    s1_valid_reg, s1_valid_next;
    tile_t   s1_tile_reg, s1_tile_next;
    logic    s2_valid_reg, s2_valid_next;
    result_t s2_result_reg, s2_result_next;
    result_t sel_result;
    logic    adv2;

    tfc_select u_select (
        .tile   (s1_tile_reg),
        .result (sel_result)
    );

    assign adv2     = !s2_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || adv2;

    always_comb
    begin
        s1_valid_next  = s_tready ? s_tvalid : s1_valid_reg;
        s1_tile_next   = s1_tile_reg;
        if (s_tvalid && s_tready)
        begin
            s1_tile_next.low  = s_tdata[63:0];
            s1_tile_next.high = s_tdata[127:64];
        end
        s2_valid_next  = adv2 ? s1_valid_reg : s2_valid_reg;
        s2_result_next = (adv2 && s1_valid_reg) ? sel_result : s2_result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tile_reg   <= s1_tile_next;
        s2_result_reg <= s2_result_next;
    end

    assign m_tvalid       = s2_valid_reg;
    assign m_tdata[63:0]  = s2_result_reg.tile.low;
    assign m_tdata[127:64] = s2_result_reg.tile.high;
    assign m_tuser[0]     = s2_result_reg.mirror_h;
    assign m_tuser[1]     = s2_result_reg.mirror_v;

`ifndef SYNTH
    tile_t chk_undo;
    assign chk_undo = flip_tile(s2_result_reg.tile, s2_result_reg.mirror_h,
                                s2_result_reg.mirror_v);

    // a stalled output keeps the waiting input item in place
    a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && m_tvalid && !m_tready |=> s1_valid_reg)
        else $error("input stage item dropped under stall");

    // output is never larger than any of its mirror images
    a_min_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (make_key(s2_result_reg.tile) <=
                      make_key(flip_tile(s2_result_reg.tile, 1'b1, 1'b0))) &&
                     (make_key(s2_result_reg.tile) <=
                      make_key(flip_tile(s2_result_reg.tile, 1'b0, 1'b1))) &&
                     (make_key(s2_result_reg.tile) <=
                      make_key(flip_tile(s2_result_reg.tile, 1'b1, 1'b1))))
        else $error("output tile is not minimal");

    // a reported flip must beat the unflipped tile strictly
    a_flip_strict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |->
            make_key(s2_result_reg.tile) < make_key(chk_undo))
        else $error("flip reported on a tie");
`endif

endmodule

// ===== hw/rtl/tfc_select.sv =====
module tfc_select
    import tfc_pkg::*;
(
    input  tile_t   tile,
    output result_t result
);

    tile_t cand0, cand1, cand2, cand3;
    key_t  key0, key1, key2, key3;
    tile_t win01, win23;
    key_t  key01, key23;
    logic  h01, h23, v23;
    logic  take1, take3, take23;

    assign cand0 = tile;
    assign cand1 = flip_tile(tile, 1'b1, 1'b0);
    assign cand2 = flip_tile(tile, 1'b0, 1'b1);
    assign cand3 = flip_tile(tile, 1'b1, 1'b1);

    assign key0 = make_key(cand0);
    assign key1 = make_key(cand1);
    assign key2 = make_key(cand2);
    assign key3 = make_key(cand3);

    // ties keep the earlier candidate
    assign take1  = key1 < key0;
    assign take3  = key3 < key2;
    assign win01  = take1 ? cand1 : cand0;
    assign key01  = take1 ? key1 : key0;
    assign h01    = take1;
    assign win23  = take3 ? cand3 : cand2;
    assign key23  = take3 ? key3 : key2;
    assign h23    = take3;
    assign v23    = 1'b1;
    assign take23 = key23 < key01;

    always_comb
    begin
        result.tile     = take23 ? win23 : win01;
        result.mirror_h = take23 ? h23 : h01;
        result.mirror_v = take23 ? v23 : 1'b0;
    end

endmodule

// ===== sim/tile_flip_canonicalizer_top_tb.sv =====
`timescale 1ns / 100ps

module tile_flip_canonicalizer_top_tb;
    import tfc_pkg::*;

    localparam int DirRows   = 20;
    localparam int RandTiles = 830;
    localparam int QuietTail = 150;

    typedef struct packed {
        plane_t low;
        plane_t high;
        logic   known;
        plane_t want_low;
        plane_t want_high;
        logic   want_h;
        logic   want_v;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;     // tile_low_plane, tile_high_plane
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;          // canon_low_plane, canon_high_plane
    logic [1:0]   m_tuser;          // mirrored_horizontally, mirrored_vertically

    result_t  canon_q[$];
    int       mismatches = 0;
    int       sink_stall = 0;
    bit       idle_on = 1'b1;
    dir_row_t dir_tab [DirRows];

    tile_flip_canonicalizer_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic plane_t flip_lr(input plane_t p);
        plane_t     r;
        logic [7:0] row;
        for (int y = 0; y < 8; y++)
        begin
            row = p[8*y +: 8];
            r[8*y +: 8] = {<<{row}};
        end
        return r;
    endfunction

    function automatic plane_t flip_tb(input plane_t p);
        return {<<8{p}};
    endfunction

    // earlier pixels land in more significant bits
    function automatic key_t pixel_rank(input plane_t lo, input plane_t hi);
        key_t k;
        int   bitpos;
        k = '0;
        for (int idx = 0; idx < 64; idx++)
        begin
            bitpos = 8 * (idx / 8) + 7 - (idx % 8);
            k = {k[KeyW-3:0], hi[bitpos], lo[bitpos]};
        end
        return k;
    endfunction

    function automatic result_t predict_canonical(input plane_t lo, input plane_t hi);
        result_t best;
        result_t cand;
        key_t    best_key;
        key_t    k;
        best.tile.low  = lo;
        best.tile.high = hi;
        best.mirror_h  = 1'b0;
        best.mirror_v  = 1'b0;
        best_key = pixel_rank(lo, hi);
        for (int c = 1; c < 4; c++)
        begin
            cand.mirror_h  = (c & 1) != 0;
            cand.mirror_v  = (c & 2) != 0;
            cand.tile.low  = lo;
            cand.tile.high = hi;
            if (cand.mirror_h)
            begin
                cand.tile.low  = flip_lr(cand.tile.low);
                cand.tile.high = flip_lr(cand.tile.high);
            end
            if (cand.mirror_v)
            begin
                cand.tile.low  = flip_tb(cand.tile.low);
                cand.tile.high = flip_tb(cand.tile.high);
            end
            k = pixel_rank(cand.tile.low, cand.tile.high);
            if (k < best_key)
            begin
                best     = cand;
                best_key = k;
            end
        end
        return best;
    endfunction

    function automatic plane_t sym_lr(input plane_t p);
        plane_t left;
        left = p & 64'hF0F0_F0F0_F0F0_F0F0;
        return left | flip_lr(left);
    endfunction

    function automatic plane_t sym_tb(input plane_t p);
        plane_t top;
        top = p & 64'h0000_0000_FFFF_FFFF;
        return top | flip_tb(top);
    endfunction

    // mix of symmetric, near-symmetric, sparse and plain random tiles
    task automatic make_random_tile(output plane_t lo, output plane_t hi);
        int         kind;
        int         pos;
        logic [1:0] pv;
        kind = $urandom_range(0, 5);
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        if (kind == 1 || kind == 3 || (kind == 5 && $urandom_range(0, 1) == 0))
        begin
            lo = sym_lr(lo);
            hi = sym_lr(hi);
        end
        if (kind == 2 || kind == 3 || kind == 5)
        begin
            lo = sym_tb(lo);
            hi = sym_tb(hi);
        end
        if (kind == 4)
        begin
            lo = '0;
            hi = '0;
            repeat ($urandom_range(1, 4))
            begin
                pos = $urandom_range(0, 63);
                pv  = 2'($urandom_range(0, 3));
                lo[pos] = pv[0];
                hi[pos] = pv[1];
            end
        end
        if (kind == 5)
        begin
            pos = $urandom_range(0, 63);
            if ($urandom_range(0, 1) == 1)
                lo[pos] = ~lo[pos];
            else
                hi[pos] = ~hi[pos];
        end
    endtask

    task automatic send_tile(input plane_t lo, input plane_t hi, input result_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do
            @(posedge clk);
        while (!s_tready);
        canon_q.push_back(want);
    endtask

    task automatic flag_mismatch(input string field, input plane_t want, input plane_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", field, want, got);
    endtask

    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= sink_stall - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            sink_stall <= $urandom_range(0, 15);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (canon_q.size() == 0)
            begin
                flag_mismatch("unexpected item", '0, m_tdata[63:0]);
            end
            else
            begin
                want = canon_q.pop_front();
                if (m_tdata[63:0] !== want.tile.low)
                    flag_mismatch("canon_low_plane", want.tile.low, m_tdata[63:0]);
                if (m_tdata[127:64] !== want.tile.high)
                    flag_mismatch("canon_high_plane", want.tile.high, m_tdata[127:64]);
                if (m_tuser[0] !== want.mirror_h)
                    flag_mismatch("mirrored_horizontally", 64'(want.mirror_h), 64'(m_tuser[0]));
                if (m_tuser[1] !== want.mirror_v)
                    flag_mismatch("mirrored_vertically", 64'(want.mirror_v), 64'(m_tuser[1]));
            end
        end
    end

    initial
    begin
        result_t want;
        plane_t  lo;
        plane_t  hi;
        int      drain;

        dir_tab = '{
            '{64'h0, 64'h0, 1'b1, 64'h0, 64'h0, 1'b0, 1'b0},
            '{'1, '1, 1'b1, '1, '1, 1'b0, 1'b0},
            '{'1, 64'h0, 1'b1, '1, 64'h0, 1'b0, 1'b0},
            '{64'h0, '1, 1'b1, 64'h0, '1, 1'b0, 1'b0},
            '{64'h80, 64'h80, 1'b1,
              64'h0100_0000_0000_0000, 64'h0100_0000_0000_0000, 1'b1, 1'b1},
            '{64'h0100_0000_0000_0000, 64'h0100_0000_0000_0000, 1'b1,
              64'h0100_0000_0000_0000, 64'h0100_0000_0000_0000, 1'b0, 1'b0},
            '{64'h8000_0000_0000_0000, 64'h0, 1'b1,
              64'h0100_0000_0000_0000, 64'h0, 1'b1, 1'b0},
            '{64'h01, 64'h0, 1'b1, 64'h0100_0000_0000_0000, 64'h0, 1'b0, 1'b1},
            '{64'h0, 64'h01, 1'b1, 64'h0, 64'h0100_0000_0000_0000, 1'b0, 1'b1},
            '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'h0, 64'h0, 1'b0, 1'b0},
            '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0, 64'h0, 1'b0, 1'b0},
            '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, 64'h0, 64'h0, 1'b0, 1'b0},
            '{64'hFF00_FF00_FF00_FF00, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, 64'h0, 64'h0, 1'b0, 1'b0},
            '{64'hFF, 64'h0, 1'b1, 64'hFF00_0000_0000_0000, 64'h0, 1'b0, 1'b1},
            '{64'h8181_8181_8181_8181, 64'h0, 1'b1,
              64'h8181_8181_8181_8181, 64'h0, 1'b0, 1'b0},
            '{64'h80, 64'h01, 1'b1,
              64'h8000_0000_0000_0000, 64'h0100_0000_0000_0000, 1'b0, 1'b1},
            '{64'hDEAD_BEEF_CAFE_F00D, 64'h0BAD_F00D_1234_5678, 1'b0, 64'h0, 64'h0, 1'b0, 1'b0},
            '{64'hFFFF_FFFF_FFFF_FFFE, '1, 1'b1, 64'hFFFF_FFFF_FFFF_FF7F, '1, 1'b1, 1'b0},
            '{64'h7FFF_FFFF_FFFF_FFFF, '1, 1'b1, 64'hFFFF_FFFF_FFFF_FF7F, '1, 1'b0, 1'b1},
            '{64'h00FF_0000_0000_00FF, 64'h0, 1'b1,
              64'hFF00_0000_0000_FF00, 64'h0, 1'b0, 1'b1}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DirRows; i++)
        begin
            if (dir_tab[i].known)
            begin
                want.tile.low  = dir_tab[i].want_low;
                want.tile.high = dir_tab[i].want_high;
                want.mirror_h  = dir_tab[i].want_h;
                want.mirror_v  = dir_tab[i].want_v;
            end
            else
            begin
                want = predict_canonical(dir_tab[i].low, dir_tab[i].high);
            end
            send_tile(dir_tab[i].low, dir_tab[i].high, want);
        end

        for (int i = 0; i < RandTiles; i++)
        begin
            if (i % 50 == 0)
                idle_on = (i < RandTiles - QuietTail) && ($urandom_range(0, 3) != 0);
            make_random_tile(lo, hi);
            send_tile(lo, hi, predict_canonical(lo, hi));
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (canon_q.size() != 0 && drain < 10000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0 && canon_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tfc_pkg.sv
hw/rtl/tfc_select.sv
hw/rtl/tile_flip_canonicalizer_top.sv
sim/tile_flip_canonicalizer_top_tb.sv
